// ===== sv/arc4_pkg.sv =====
// Shared constants for the ARC4 keystream generator: opcodes and default sizes.
// No dependencies; imported by arc4_keystream_generator_top.
package arc4_pkg;

   localparam int KEY_CHUNK_DEFAULT     = 256;
   localparam int DISCARD_BYTES_DEFAULT = 1024;

   localparam int OPCODE_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_REINIT  = 3'd0,
      OP_KEY     = 3'd1,
      OP_WORD32  = 3'd2,
      OP_WORD64  = 3'd3,
      OP_DISCARD = 3'd4
   } opcode_type;

   // Steps of one mixing pass, one per permutation entry.
   localparam int MIX_STEPS = 256;

endpackage

// ===== sv/arc4_keystream_generator_top.sv =====
// ARC4 keystream generator: permutation memory with a read-swap-write sequencer.
// Each keystream or mixing step runs through RD_I, RD_J, WR_I and WR_J, set by the single read and single write
// port of the permutation memory. One item at a time: a key byte is buffered, and one that closes a
// chunk also starts a mixing pass; reinit reloads the identity permutation; word32 and word64 take 4
// and 8 keystream bytes and raise rsp_tvalid once the output register is free; discard skips DISCARD_BYTES.
// Reset (synchronous, active high) loads the identity permutation with req_tready low; uses arc4_pkg.
module arc4_keystream_generator_top
   import arc4_pkg::*;
#(
   parameter int KEY_CHUNK     = KEY_CHUNK_DEFAULT,
   parameter int DISCARD_BYTES = DISCARD_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] key_byte
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   input  logic        req_tlast,   // last_key_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] random_value
   output logic        rsp_tuser    // [0] is_wide
);

   localparam int KA_W  = (KEY_CHUNK > 1) ? $clog2(KEY_CHUNK) : 1;
   localparam int KC_W  = $clog2(KEY_CHUNK + 1);
   localparam int MAX_S = (DISCARD_BYTES > MIX_STEPS) ? DISCARD_BYTES : MIX_STEPS;
   localparam int RC_W  = $clog2(MAX_S + 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_RD_I = 7'b0000100,
      ST_RD_J = 7'b0001000,
      ST_WR_I = 7'b0010000,
      ST_WR_J = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   // Memories.
   logic [7:0] perm_mem [256];
   logic [7:0] key_mem  [KEY_CHUNK];

   // Control registers.
   state_type         state_ff, state_in;
   logic [7:0]        init_cnt_ff, init_cnt_in;
   logic [7:0]        i_ff, i_in;
   logic [7:0]        j_ff, j_in;
   logic [KC_W-1:0]   key_count_ff, key_count_in;
   logic [KC_W-1:0]   len_ff, len_in;
   logic [KA_W-1:0]   kidx_ff, kidx_in;
   logic [RC_W-1:0]   rem_ff, rem_in;
   logic              mix_ff, mix_in;
   logic              out_op_ff, out_op_in;
   logic              wide_ff, wide_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [7:0]        perm_rd_ff;
   logic [7:0]        key_rd_ff;
   logic [7:0]        a_ff;
   logic [7:0]        b_ff;
   logic [7:0]        sum_ff;
   logic [63:0]       shift_ff;
   logic [63:0]       rsp_data_ff;
   logic              rsp_wide_ff;

   // Memory port controls.
   logic [7:0]        perm_raddr;
   logic              perm_we;
   logic [7:0]        perm_waddr;
   logic [7:0]        perm_wdata;
   logic              key_we;

   logic              req_fire;
   opcode_type        req_op;
   logic [KC_W-1:0]   key_count_nxt;
   logic [7:0]        j_sum;
   logic [7:0]        byte_val;
   logic              out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = opcode_type'(req_tuser);
   assign key_we     = req_fire && (req_op == OP_KEY);
   assign key_count_nxt = key_count_ff + KC_W'(1);

   assign j_sum = j_ff + perm_rd_ff + (mix_ff ? key_rd_ff : 8'd0);

   // The swap is only half done when the output read is issued, so the two
   // swapped entries are taken from registers rather than from the memory.
   assign byte_val = (sum_ff == j_ff) ? a_ff :
                     (sum_ff == i_ff) ? b_ff : perm_rd_ff;

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      perm_raddr = i_ff + 8'd1;
      perm_we    = 1'b0;
      perm_waddr = i_ff;
      perm_wdata = perm_rd_ff;
      case (state_ff)
         ST_INIT: begin
            perm_we    = 1'b1;
            perm_waddr = init_cnt_ff;
            perm_wdata = init_cnt_ff;
         end
         ST_RD_J: begin
            perm_raddr = j_sum;
         end
         ST_WR_I: begin
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rd_ff;
            perm_raddr = a_ff + perm_rd_ff;
         end
         ST_WR_J: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = a_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      key_count_in = key_count_ff;
      len_in       = len_ff;
      kidx_in      = kidx_ff;
      rem_in       = rem_ff;
      mix_in       = mix_ff;
      out_op_in    = out_op_ff;
      wide_in      = wide_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_REINIT: begin
                     state_in    = ST_INIT;
                     init_cnt_in = 8'd0;
                  end
                  OP_KEY: begin
                     key_count_in = key_count_nxt;
                     if (req_tlast || key_count_nxt == KC_W'(KEY_CHUNK)) begin
                        key_count_in = '0;
                        len_in       = key_count_nxt;
                        kidx_in      = '0;
                        mix_in       = 1'b1;
                        out_op_in    = 1'b0;
                        // Each step pre-increments i, so the pass begins at i.
                        i_in         = i_ff - 8'd1;
                        rem_in       = RC_W'(MIX_STEPS);
                        state_in     = ST_RD_I;
                     end
                  end
                  OP_WORD32: begin
                     mix_in    = 1'b0;
                     out_op_in = 1'b1;
                     wide_in   = 1'b0;
                     rem_in    = RC_W'(4);
                     state_in  = ST_RD_I;
                  end
                  OP_WORD64: begin
                     mix_in    = 1'b0;
                     out_op_in = 1'b1;
                     wide_in   = 1'b1;
                     rem_in    = RC_W'(8);
                     state_in  = ST_RD_I;
                  end
                  OP_DISCARD: begin
                     mix_in    = 1'b0;
                     out_op_in = 1'b0;
                     rem_in    = RC_W'(DISCARD_BYTES);
                     if (DISCARD_BYTES != 0) begin
                        state_in = ST_RD_I;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            init_cnt_in = init_cnt_ff + 8'd1;
            if (init_cnt_ff == 8'hff) begin
               state_in = ST_IDLE;
               i_in     = 8'd0;
               j_in     = 8'd0;
            end
         end
         ST_RD_I: begin
            i_in     = i_ff + 8'd1;
            state_in = ST_RD_J;
         end
         ST_RD_J: begin
            j_in     = j_sum;
            state_in = ST_WR_I;
         end
         ST_WR_I: begin
            state_in = ST_WR_J;
         end
         ST_WR_J: begin
            rem_in = rem_ff - RC_W'(1);
            if (mix_ff) begin
               if (KC_W'(kidx_ff) == len_ff - KC_W'(1)) begin
                  kidx_in = '0;
               end else begin
                  kidx_in = kidx_ff + KA_W'(1);
               end
            end
            if (rem_ff == RC_W'(1)) begin
               state_in = out_op_ff ? ST_OUT : ST_IDLE;
            end else begin
               state_in = ST_RD_I;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= 8'd0;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         key_count_ff <= '0;
         len_ff       <= KC_W'(1);
         kidx_ff      <= '0;
         rem_ff       <= '0;
         mix_ff       <= 1'b0;
         out_op_ff    <= 1'b0;
         wide_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_count_ff <= key_count_in;
         len_ff       <= len_in;
         kidx_ff      <= kidx_in;
         rem_ff       <= rem_in;
         mix_ff       <= mix_in;
         out_op_ff    <= out_op_in;
         wide_ff      <= wide_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Permutation memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_waddr] <= perm_wdata;
      end
      perm_rd_ff <= perm_mem[perm_raddr];
   end

   // Key buffer: written on key beats, read at the running key index.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_count_ff[KA_W-1:0]] <= req_tdata;
      end
      key_rd_ff <= key_mem[kidx_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RD_J) begin
         a_ff <= perm_rd_ff;
      end
      if (state_ff == ST_WR_I) begin
         b_ff   <= perm_rd_ff;
         sum_ff <= a_ff + perm_rd_ff;
      end
      if (req_fire) begin
         shift_ff <= 64'd0;
      end else if (state_ff == ST_WR_J && !mix_ff) begin
         shift_ff <= {shift_ff[55:0], byte_val};
      end
      if (out_load) begin
         rsp_data_ff <= shift_ff;
         rsp_wide_ff <= wide_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_wide_ff;

   // The sequencer state is always a single one-hot code.
   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   // A buffered chunk never reaches the chunk size without being mixed.
   assert property (@(posedge clock) disable iff (reset)
      key_count_ff < KC_W'(KEY_CHUNK))
      else $error("key count reached the chunk size");

   // The mixing pass never runs with an empty key.
   assert property (@(posedge clock) disable iff (reset)
      (mix_ff && state_ff == ST_RD_I) |-> (len_ff != '0))
      else $error("mixing pass with zero key length");

   // A swap always completes: the first write is followed by the second.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_I) |=> (state_ff == ST_WR_J))
      else $error("swap interrupted");

   // A word is loaded only into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");

endmodule
